// File: hw/rtl/abb_pkg.sv
// ----------------------------------------------------------------------------
// abb_pkg
// Shared constants and types for the arc bounding box pipeline.
// ----------------------------------------------------------------------------
package abb_pkg;

  // default widths handed to the top level parameters
  localparam int unsigned CoordWidthDef = 24;
  localparam int unsigned TrigFracDef   = 16;

  // fixed field widths
  localparam int unsigned StartWidth  = 16;
  localparam int unsigned SweepWidth  = 10;
  localparam int unsigned AngleWidth  = 9;   // 0..359
  localparam int unsigned SpanWidth   = 10;  // 0..719
  localparam int unsigned TblIdxWidth = 7;   // 0..90
  localparam int unsigned TblDepth    = 91;

  // angle landmarks in degrees
  localparam int unsigned QuarterTurn      = 90;
  localparam int unsigned HalfTurn         = 180;
  localparam int unsigned ThreeQuarterTurn = 270;
  localparam int unsigned FullTurn         = 360;

  // modulo 360 by reciprocal multiply: offset keeps the operand positive,
  // the quotient by 360 equals (v * RecipMul) >> RecipShift for all v below
  // 2^NormWidth
  localparam int unsigned NormWidth  = 17;
  localparam int unsigned NormOffset = 36000;
  localparam int unsigned RecipMul   = 93207;
  localparam int unsigned RecipWidth = 17;
  localparam int unsigned RecipShift = 25;
  localparam int unsigned QuotWidth  = 8;

  // sweep saturation limits
  localparam logic signed [SweepWidth-1:0] SweepMax = 10'sd360;
  localparam logic signed [SweepWidth-1:0] SweepMin = -10'sd360;

  // pi in Q30
  localparam longint PiQ30 = 64'sd3373259426;

  // box sides pushed out to the full circle
  typedef struct packed {
    logic max_y;
    logic min_x;
    logic min_y;
    logic max_x;
  } cross_t;

endpackage

// File: hw/rtl/abb_angle_norm.sv
// ----------------------------------------------------------------------------
// abb_angle_norm
// Two pipeline stages: saturate the sweep, reduce both endpoint angles
// modulo 360 and form the crossing span lo..hi.
// ----------------------------------------------------------------------------
module abb_angle_norm (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [abb_pkg::StartWidth-1:0]  start_angle_i,
  input  logic signed [abb_pkg::SweepWidth-1:0]  sweep_angle_i,
  output logic                                   valid_o,
  output logic        [abb_pkg::AngleWidth-1:0]  a0_o,
  output logic        [abb_pkg::AngleWidth-1:0]  a1_o,
  output logic        [abb_pkg::SpanWidth-1:0]   lo_o,
  output logic        [abb_pkg::SpanWidth-1:0]   hi_o
);
  import abb_pkg::*;

  localparam int unsigned ExtWidth  = NormWidth + 1;
  localparam int unsigned ProdWidth = NormWidth + RecipWidth;
  localparam logic signed [ExtWidth-1:0] OffsetS = ExtWidth'(NormOffset);
  localparam logic [ProdWidth-1:0] RecipK = ProdWidth'(RecipMul);
  localparam logic [NormWidth-1:0] TurnN  = NormWidth'(FullTurn);

  logic signed [SweepWidth-1:0] sw_clamp;
  logic signed [ExtWidth-1:0]   st_ext;
  logic signed [ExtWidth-1:0]   sw_ext;
  logic signed [ExtWidth-1:0]   v0_ext;
  logic signed [ExtWidth-1:0]   v1_ext;
  logic        [ProdWidth-1:0]  p0;
  logic        [ProdWidth-1:0]  p1;

  logic                         s1_valid_q;
  logic        [NormWidth-1:0]  v0_q;
  logic        [NormWidth-1:0]  v1_q;
  logic        [QuotWidth-1:0]  q0_q;
  logic        [QuotWidth-1:0]  q1_q;
  logic signed [SweepWidth-1:0] sw_q;

  logic        [NormWidth-1:0]  r0;
  logic        [NormWidth-1:0]  r1;
  logic        [SpanWidth-1:0]  sw_mag;
  logic        [SpanWidth-1:0]  lo_d;

  // sweep saturation to one full turn
  always_comb begin
    if (sweep_angle_i > SweepMax) begin
      sw_clamp = SweepMax;
    end else if (sweep_angle_i < SweepMin) begin
      sw_clamp = SweepMin;
    end else begin
      sw_clamp = sweep_angle_i;
    end
  end

  // offset to positive, then quotient by reciprocal multiply
  assign st_ext = ExtWidth'(start_angle_i);
  assign sw_ext = ExtWidth'(sw_clamp);
  assign v0_ext = st_ext + OffsetS;
  assign v1_ext = st_ext + sw_ext + OffsetS;
  assign p0     = ProdWidth'(v0_ext[NormWidth-1:0]) * RecipK;
  assign p1     = ProdWidth'(v1_ext[NormWidth-1:0]) * RecipK;

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q <= v0_ext[NormWidth-1:0];
    v1_q <= v1_ext[NormWidth-1:0];
    q0_q <= p0[RecipShift +: QuotWidth];
    q1_q <= p1[RecipShift +: QuotWidth];
    sw_q <= sw_clamp;
  end

  // remainders and crossing span
  assign r0     = v0_q - NormWidth'(q0_q) * TurnN;
  assign r1     = v1_q - NormWidth'(q1_q) * TurnN;
  assign sw_mag = sw_q[SweepWidth-1] ? SpanWidth'(-sw_q) : SpanWidth'(sw_q);
  assign lo_d   = sw_q[SweepWidth-1] ? SpanWidth'(r1[AngleWidth-1:0])
                                     : SpanWidth'(r0[AngleWidth-1:0]);

  // stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a0_o <= r0[AngleWidth-1:0];
    a1_o <= r1[AngleWidth-1:0];
    lo_o <= lo_d;
    hi_o <= lo_d + sw_mag;
  end

endmodule

// File: hw/rtl/abb_trig.sv
// ----------------------------------------------------------------------------
// abb_trig
// One pipeline stage: quadrant split, quarter-wave table lookup for sine and
// cosine of both endpoints, and detection of the axis crossings.
// ----------------------------------------------------------------------------
module abb_trig #(
  parameter int unsigned TrigFracBits = abb_pkg::TrigFracDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic        [abb_pkg::AngleWidth-1:0] a0_i,
  input  logic        [abb_pkg::AngleWidth-1:0] a1_i,
  input  logic        [abb_pkg::SpanWidth-1:0]  lo_i,
  input  logic        [abb_pkg::SpanWidth-1:0]  hi_i,
  output logic                                  valid_o,
  output logic signed [TrigFracBits+1:0]        sin0_o,
  output logic signed [TrigFracBits+1:0]        cos0_o,
  output logic signed [TrigFracBits+1:0]        sin1_o,
  output logic signed [TrigFracBits+1:0]        cos1_o,
  output abb_pkg::cross_t                       cross_o
);
  import abb_pkg::*;

  localparam int unsigned TblWidth  = TrigFracBits + 1;
  localparam int unsigned TrigWidth = TrigFracBits + 2;

  localparam logic [1:0] QuadFirst  = 2'd0;
  localparam logic [1:0] QuadSecond = 2'd1;
  localparam logic [1:0] QuadThird  = 2'd2;
  localparam logic [1:0] QuadFourth = 2'd3;

  logic        [TblWidth-1:0]    sin_tbl [TblDepth];
  logic        [AngleWidth-1:0]  ang     [2];
  logic        [1:0]             quad    [2];
  logic        [TblIdxWidth-1:0] k       [2];
  logic        [TblIdxWidth-1:0] kc      [2];
  logic signed [TrigWidth-1:0]   tk      [2];
  logic signed [TrigWidth-1:0]   tc      [2];
  logic signed [TrigWidth-1:0]   sin_d   [2];
  logic signed [TrigWidth-1:0]   cos_d   [2];
  cross_t                        cross_d;

  // strict crossing test, also one turn later
  function automatic logic crossed(logic [SpanWidth-1:0] lo, logic [SpanWidth-1:0] hi,
                                   logic [SpanWidth-1:0] c);
    logic [SpanWidth-1:0] c2;
    c2 = c + SpanWidth'(FullTurn);
    return ((lo < c) && (hi > c)) || ((lo < c2) && (hi > c2));
  endfunction

  // constant quarter-wave table: sin(k degrees) by Taylor series in Q30,
  // rounded half up to the fraction width and clamped to one
  for (genvar gi = 0; gi < TblDepth; gi++) begin : g_tbl
    localparam longint X      = (longint'(gi) * PiQ30) / 180;
    localparam longint X2     = (X * X) >>> 30;
    localparam longint T3     = ((X * X2) >>> 30) / 6;
    localparam longint T5     = ((T3 * X2) >>> 30) / 20;
    localparam longint T7     = ((T5 * X2) >>> 30) / 42;
    localparam longint T9     = ((T7 * X2) >>> 30) / 72;
    localparam longint T11    = ((T9 * X2) >>> 30) / 110;
    localparam longint T13    = ((T11 * X2) >>> 30) / 156;
    localparam longint T15    = ((T13 * X2) >>> 30) / 210;
    localparam longint Sum    = X - T3 + T5 - T7 + T9 - T11 + T13 - T15;
    localparam longint SumPos = (Sum < 0) ? 64'sd0 : Sum;
    localparam longint Half   = longint'(1) <<< (29 - TrigFracBits);
    localparam longint Rnd    = (SumPos + Half) >>> (30 - TrigFracBits);
    localparam longint One    = longint'(1) <<< TrigFracBits;
    localparam longint Val    = (Rnd > One) ? One : Rnd;
    assign sin_tbl[gi] = TblWidth'(Val);
  end

  assign ang[0] = a0_i;
  assign ang[1] = a1_i;

  // quadrant fold and sign selection per endpoint
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (ang[i] >= AngleWidth'(ThreeQuarterTurn)) begin
        quad[i] = QuadFourth;
      end else if (ang[i] >= AngleWidth'(HalfTurn)) begin
        quad[i] = QuadThird;
      end else if (ang[i] >= AngleWidth'(QuarterTurn)) begin
        quad[i] = QuadSecond;
      end else begin
        quad[i] = QuadFirst;
      end
      k[i]  = TblIdxWidth'(ang[i] - AngleWidth'(QuarterTurn) * AngleWidth'(quad[i]));
      kc[i] = TblIdxWidth'(QuarterTurn) - k[i];
      tk[i] = $signed({1'b0, sin_tbl[k[i]]});
      tc[i] = $signed({1'b0, sin_tbl[kc[i]]});
      unique case (quad[i])
        QuadFirst: begin
          sin_d[i] = tk[i];
          cos_d[i] = tc[i];
        end
        QuadSecond: begin
          sin_d[i] = tc[i];
          cos_d[i] = -tk[i];
        end
        QuadThird: begin
          sin_d[i] = -tk[i];
          cos_d[i] = -tc[i];
        end
        default: begin
          sin_d[i] = -tc[i];
          cos_d[i] = tk[i];
        end
      endcase
    end
  end

  // axis crossings
  always_comb begin
    cross_d.max_y = crossed(lo_i, hi_i, SpanWidth'(QuarterTurn));
    cross_d.min_x = crossed(lo_i, hi_i, SpanWidth'(HalfTurn));
    cross_d.min_y = crossed(lo_i, hi_i, SpanWidth'(ThreeQuarterTurn));
    cross_d.max_x = crossed(lo_i, hi_i, SpanWidth'(FullTurn));
  end

  // stage 3 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sin0_o  <= sin_d[0];
    cos0_o  <= cos_d[0];
    sin1_o  <= sin_d[1];
    cos1_o  <= cos_d[1];
    cross_o <= cross_d;
  end

endmodule

// File: hw/rtl/abb_endpoint.sv
// ----------------------------------------------------------------------------
// abb_endpoint
// Two pipeline stages: radius times sine and cosine, then the center added
// in fixed point to give both endpoints.
// ----------------------------------------------------------------------------
module abb_endpoint #(
  parameter int unsigned CoordWidth   = abb_pkg::CoordWidthDef,
  parameter int unsigned TrigFracBits = abb_pkg::TrigFracDef
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  abb_pkg::cross_t                          cross_i,
  input  logic signed [TrigFracBits+1:0]           sin0_i,
  input  logic signed [TrigFracBits+1:0]           cos0_i,
  input  logic signed [TrigFracBits+1:0]           sin1_i,
  input  logic signed [TrigFracBits+1:0]           cos1_i,
  input  logic        [CoordWidth-2:0]             radius_i,
  input  logic signed [CoordWidth-1:0]             ctr_x_i,
  input  logic signed [CoordWidth-1:0]             ctr_y_i,
  output logic                                     valid_o,
  output abb_pkg::cross_t                          cross_o,
  output logic signed [CoordWidth+TrigFracBits+1:0] x0_o,
  output logic signed [CoordWidth+TrigFracBits+1:0] y0_o,
  output logic signed [CoordWidth+TrigFracBits+1:0] x1_o,
  output logic signed [CoordWidth+TrigFracBits+1:0] y1_o
);
  import abb_pkg::*;

  localparam int unsigned EpWidth = CoordWidth + TrigFracBits + 2;

  logic signed [CoordWidth-1:0]              rad_s;
  logic                                      s4_valid_q;
  cross_t                                    s4_cross_q;
  logic signed [EpWidth-1:0]                 px0_q;
  logic signed [EpWidth-1:0]                 py0_q;
  logic signed [EpWidth-1:0]                 px1_q;
  logic signed [EpWidth-1:0]                 py1_q;
  logic signed [CoordWidth+TrigFracBits-1:0] cx_sh;
  logic signed [CoordWidth+TrigFracBits-1:0] cy_sh;

  assign rad_s = $signed({1'b0, radius_i});

  // stage 4: radius products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_cross_q <= cross_i;
    px0_q      <= EpWidth'(rad_s) * EpWidth'(cos0_i);
    py0_q      <= EpWidth'(rad_s) * EpWidth'(sin0_i);
    px1_q      <= EpWidth'(rad_s) * EpWidth'(cos1_i);
    py1_q      <= EpWidth'(rad_s) * EpWidth'(sin1_i);
  end

  // center scaled to the fixed-point grid
  assign cx_sh = $signed({ctr_x_i, {TrigFracBits{1'b0}}});
  assign cy_sh = $signed({ctr_y_i, {TrigFracBits{1'b0}}});

  // stage 5: endpoint sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cross_o <= s4_cross_q;
    x0_o    <= EpWidth'(cx_sh) + px0_q;
    y0_o    <= EpWidth'(cy_sh) + py0_q;
    x1_o    <= EpWidth'(cx_sh) + px1_q;
    y1_o    <= EpWidth'(cy_sh) + py1_q;
  end

endmodule

// File: hw/rtl/abb_box.sv
// ----------------------------------------------------------------------------
// abb_box
// Final pipeline stage: order the endpoints, floor the minima, ceil the
// maxima and push crossed sides out to the full circle.
// ----------------------------------------------------------------------------
module abb_box #(
  parameter int unsigned CoordWidth   = abb_pkg::CoordWidthDef,
  parameter int unsigned TrigFracBits = abb_pkg::TrigFracDef
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  input  abb_pkg::cross_t                          cross_i,
  input  logic signed [CoordWidth+TrigFracBits+1:0] x0_i,
  input  logic signed [CoordWidth+TrigFracBits+1:0] y0_i,
  input  logic signed [CoordWidth+TrigFracBits+1:0] x1_i,
  input  logic signed [CoordWidth+TrigFracBits+1:0] y1_i,
  input  logic signed [CoordWidth-1:0]             ctr_x_i,
  input  logic signed [CoordWidth-1:0]             ctr_y_i,
  input  logic        [CoordWidth-2:0]             radius_i,
  output logic                                     valid_o,
  output logic signed [CoordWidth:0]               min_x_o,
  output logic signed [CoordWidth:0]               max_x_o,
  output logic signed [CoordWidth:0]               min_y_o,
  output logic signed [CoordWidth:0]               max_y_o
);
  import abb_pkg::*;

  localparam int unsigned EpWidth  = CoordWidth + TrigFracBits + 2;
  localparam int unsigned OutWidth = CoordWidth + 1;
  localparam logic [EpWidth-1:0] FracMask =
    {{(EpWidth - TrigFracBits){1'b0}}, {TrigFracBits{1'b1}}};

  logic signed [EpWidth-1:0]  x_lo;
  logic signed [EpWidth-1:0]  x_hi;
  logic signed [EpWidth-1:0]  y_lo;
  logic signed [EpWidth-1:0]  y_hi;
  logic        [EpWidth-1:0]  x_hi_c;
  logic        [EpWidth-1:0]  y_hi_c;
  logic        [OutWidth-1:0] cx_ext;
  logic        [OutWidth-1:0] cy_ext;
  logic        [OutWidth-1:0] r_ext;
  logic        [OutWidth-1:0] min_x_d;
  logic        [OutWidth-1:0] max_x_d;
  logic        [OutWidth-1:0] min_y_d;
  logic        [OutWidth-1:0] max_y_d;

  // endpoint ordering
  assign x_lo = (x0_i < x1_i) ? x0_i : x1_i;
  assign x_hi = (x0_i < x1_i) ? x1_i : x0_i;
  assign y_lo = (y0_i < y1_i) ? y0_i : y1_i;
  assign y_hi = (y0_i < y1_i) ? y1_i : y0_i;

  // ceil by adding the fraction mask before truncation
  assign x_hi_c = $unsigned(x_hi) + FracMask;
  assign y_hi_c = $unsigned(y_hi) + FracMask;

  assign cx_ext = OutWidth'(ctr_x_i);
  assign cy_ext = OutWidth'(ctr_y_i);
  assign r_ext  = OutWidth'(radius_i);

  // floor/ceil and crossing overrides
  always_comb begin
    min_x_d = cross_i.min_x ? cx_ext - r_ext : x_lo[TrigFracBits +: OutWidth];
    max_x_d = cross_i.max_x ? cx_ext + r_ext : x_hi_c[TrigFracBits +: OutWidth];
    min_y_d = cross_i.min_y ? cy_ext - r_ext : y_lo[TrigFracBits +: OutWidth];
    max_y_d = cross_i.max_y ? cy_ext + r_ext : y_hi_c[TrigFracBits +: OutWidth];
  end

  // stage 6: output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    min_x_o <= min_x_d;
    max_x_o <= max_x_d;
    min_y_o <= min_y_d;
    max_y_o <= max_y_d;
  end

endmodule

// File: hw/rtl/arc_bounding_box_core.sv
// ----------------------------------------------------------------------------
// arc_bounding_box_core
// Integer bounding box of one circular arc per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising clock edge with start high and busy low.
//   busy stays low: the pipeline takes one request in every cycle.
//   Each request gives center, radius, start angle and signed sweep in
//   whole degrees.
//   The box appears on min_x_o, max_x_o, min_y_o and max_y_o for one cycle,
//   marked by done_o, once the request has passed all register stages, in
//   request order.
//   Stages: sweep clamp and reciprocal multiply, modulo-360 remainder and
//   span, quarter-wave table and crossings, radius products, center sums,
//   floor/ceil with crossing overrides, in six register stages; the
//   throughput is one request per cycle.
//   The receiver has no way to stall the block, so a result is never held.
//   Reset clears all stage valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
module arc_bounding_box_core #(
  parameter int unsigned CoordWidth   = abb_pkg::CoordWidthDef,
  parameter int unsigned TrigFracBits = abb_pkg::TrigFracDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [CoordWidth-1:0]          ctr_x_i,
  input  logic signed [CoordWidth-1:0]          ctr_y_i,
  input  logic        [CoordWidth-2:0]          radius_i,
  input  logic signed [abb_pkg::StartWidth-1:0] start_angle_i,
  input  logic signed [abb_pkg::SweepWidth-1:0] sweep_angle_i,
  output logic                                  done_o,
  output logic signed [CoordWidth:0]            min_x_o,
  output logic signed [CoordWidth:0]            max_x_o,
  output logic signed [CoordWidth:0]            min_y_o,
  output logic signed [CoordWidth:0]            max_y_o
);
  import abb_pkg::*;

  localparam int unsigned PayDepth  = 5;
  localparam int unsigned TrigWidth = TrigFracBits + 2;
  localparam int unsigned EpWidth   = CoordWidth + TrigFracBits + 2;

  logic signed [CoordWidth-1:0] cx_q  [PayDepth];
  logic signed [CoordWidth-1:0] cy_q  [PayDepth];
  logic        [CoordWidth-2:0] rad_q [PayDepth];

  logic                         nm_valid;
  logic        [AngleWidth-1:0] nm_a0;
  logic        [AngleWidth-1:0] nm_a1;
  logic        [SpanWidth-1:0]  nm_lo;
  logic        [SpanWidth-1:0]  nm_hi;

  logic                         tr_valid;
  logic signed [TrigWidth-1:0]  tr_sin0;
  logic signed [TrigWidth-1:0]  tr_cos0;
  logic signed [TrigWidth-1:0]  tr_sin1;
  logic signed [TrigWidth-1:0]  tr_cos1;
  cross_t                       tr_cross;

  logic                         ep_valid;
  cross_t                       ep_cross;
  logic signed [EpWidth-1:0]    ep_x0;
  logic signed [EpWidth-1:0]    ep_y0;
  logic signed [EpWidth-1:0]    ep_x1;
  logic signed [EpWidth-1:0]    ep_y1;

  // fully pipelined, never holds off a request
  assign busy = 1'b0;

  // center and radius follow the request down the pipe
  always_ff @(posedge clk_i) begin
    cx_q[0]  <= ctr_x_i;
    cy_q[0]  <= ctr_y_i;
    rad_q[0] <= radius_i;
    for (int i = 1; i < PayDepth; i++) begin
      cx_q[i]  <= cx_q[i-1];
      cy_q[i]  <= cy_q[i-1];
      rad_q[i] <= rad_q[i-1];
    end
  end

  // stages 1-2: angle reduction
  abb_angle_norm u_norm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start & ~busy),
    .start_angle_i (start_angle_i),
    .sweep_angle_i (sweep_angle_i),
    .valid_o       (nm_valid),
    .a0_o          (nm_a0),
    .a1_o          (nm_a1),
    .lo_o          (nm_lo),
    .hi_o          (nm_hi)
  );

  // stage 3: sine, cosine and crossings
  abb_trig #(
    .TrigFracBits (TrigFracBits)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nm_valid),
    .a0_i    (nm_a0),
    .a1_i    (nm_a1),
    .lo_i    (nm_lo),
    .hi_i    (nm_hi),
    .valid_o (tr_valid),
    .sin0_o  (tr_sin0),
    .cos0_o  (tr_cos0),
    .sin1_o  (tr_sin1),
    .cos1_o  (tr_cos1),
    .cross_o (tr_cross)
  );

  // stages 4-5: endpoints
  abb_endpoint #(
    .CoordWidth   (CoordWidth),
    .TrigFracBits (TrigFracBits)
  ) u_endpoint (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (tr_valid),
    .cross_i  (tr_cross),
    .sin0_i   (tr_sin0),
    .cos0_i   (tr_cos0),
    .sin1_i   (tr_sin1),
    .cos1_i   (tr_cos1),
    .radius_i (rad_q[2]),
    .ctr_x_i  (cx_q[3]),
    .ctr_y_i  (cy_q[3]),
    .valid_o  (ep_valid),
    .cross_o  (ep_cross),
    .x0_o     (ep_x0),
    .y0_o     (ep_y0),
    .x1_o     (ep_x1),
    .y1_o     (ep_y1)
  );

  // stage 6: box
  abb_box #(
    .CoordWidth   (CoordWidth),
    .TrigFracBits (TrigFracBits)
  ) u_box (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ep_valid),
    .cross_i  (ep_cross),
    .x0_i     (ep_x0),
    .y0_i     (ep_y0),
    .x1_i     (ep_x1),
    .y1_i     (ep_y1),
    .ctr_x_i  (cx_q[4]),
    .ctr_y_i  (cy_q[4]),
    .radius_i (rad_q[4]),
    .valid_o  (done_o),
    .min_x_o  (min_x_o),
    .max_x_o  (max_x_o),
    .min_y_o  (min_y_o),
    .max_y_o  (max_y_o)
  );

  // every result comes from an earlier request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 6))
    else $error("result without a matching request");

  // a table stage item always reaches the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tr_valid |-> ##3 done_o)
    else $error("request lost between table stage and output");

  // box sides never cross over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (min_x_o <= max_x_o))
    else $error("min_x above max_x");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (min_y_o <= max_y_o))
    else $error("min_y above max_y");

endmodule
